// File: rtl/sound_source_polar_position_macros.svh
// ----------------------------------------------------------------------------
// sound_source_polar_position_macros
// Assertion helpers shared by the RTL of the polar position block.
// ----------------------------------------------------------------------------
`ifndef SOUND_SOURCE_POLAR_POSITION_MACROS_SVH
`define SOUND_SOURCE_POLAR_POSITION_MACROS_SVH

// cond must hold at every clock edge outside reset
`define SSP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define SSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Constants, types and the arctangent table of the polar position block.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int COORD_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 18;
	localparam int CFG_BITS         = 12;
	localparam int CFG_IDX_BITS     = 2;
	localparam int ZW               = 25;   // Q16 degree accumulator
	localparam int CW               = 60;   // CORDIC x/y datapath
	localparam int CORDIC_TOP       = 56;   // operands sit at 2^(56-COORD_BITS)
	localparam int DIST_STAGES      = 11;   // d2, rhs, nine search bits
	localparam int N_BITS           = 9;
	localparam int R2_BITS          = 25;

	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST  = 12'd640;
	localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RST = 12'd480;

	localparam logic [13:0] DIST_SCALE_SQ = 14'd16129;

	typedef struct packed {
		logic dx_pos;
		logic dy_pos;
		logic dy_zero;
		logic a_zero;
		logic a_eq_b;
	} ssp_flags_t;

	// atan(2^-i) in degrees, Q16, rounded
	function automatic logic signed [ZW-1:0] atan_q16(input int i);
		logic signed [ZW-1:0] v;
		unique case (i)
			0: v = 25'sd2949120;
			1: v = 25'sd1740967;
			2: v = 25'sd919879;
			3: v = 25'sd466945;
			4: v = 25'sd234379;
			5: v = 25'sd117304;
			6: v = 25'sd58666;
			7: v = 25'sd29335;
			8: v = 25'sd14668;
			9: v = 25'sd7334;
			10: v = 25'sd3667;
			11: v = 25'sd1833;
			12: v = 25'sd917;
			13: v = 25'sd458;
			14: v = 25'sd229;
			15: v = 25'sd115;
			16: v = 25'sd57;
			17: v = 25'sd29;
			18: v = 25'sd14;
			19: v = 25'sd7;
			20: v = 25'sd4;
			21: v = 25'sd2;
			22: v = 25'sd1;
			default: v = 25'sd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/sound_source_polar_position.sv
// ----------------------------------------------------------------------------
// sound_source_polar_position
// Bearing (vectoring CORDIC) and scaled distance (bitwise root search) of a
// sound source seen from a listener, one beat per clock.
// ----------------------------------------------------------------------------
// From start to done a beat passes the difference stage, the leg stage, the CORDIC stages and the output register.
// Throughput: one beat per cycle; busy stays low, set by one CORDIC step per stage.
// The distance search (11 stages) runs beside the CORDIC chain and is padded to it.
// Reset clears the valid bits and loads screen 640 x 480; payload is not reset.
// The receiver cannot stall: done marks each result for exactly one cycle.
`include "sound_source_polar_position_macros.svh"

module sound_source_polar_position #(
	parameter int COORD_BITS   = ssp_pkg::COORD_BITS_DEF,
	parameter int CORDIC_STEPS = ssp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [ssp_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [ssp_pkg::CFG_BITS-1:0]        wr_data,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_BITS-1:0]        listener_x,
	input  logic signed [COORD_BITS-1:0]        listener_y,
	input  logic signed [COORD_BITS-1:0]        source_x,
	input  logic signed [COORD_BITS-1:0]        source_y,
	output logic                                done,
	output logic [8:0]                          bearing_deg,
	output logic [7:0]                          scaled_distance
);

	localparam int N   = CORDIC_STEPS;
	localparam int CB  = COORD_BITS;
	localparam int CW  = ssp_pkg::CW;
	localparam int ZW  = ssp_pkg::ZW;
	localparam int SH  = ssp_pkg::CORDIC_TOP - CB;
	localparam int NB  = ssp_pkg::N_BITS;
	localparam int RB  = ssp_pkg::R2_BITS;
	localparam int D2W = 2 * CB + 1;
	localparam int SW  = (2 * CB + 16 > 48) ? 2 * CB + 16 : 48;

	// ---------------- configuration ----------------
	logic [ssp_pkg::CFG_BITS-1:0] screen_width_q, screen_height_q;
	logic [RB-2:0]                p2_q, q2_q;
	logic [RB-1:0]                r2_q;
	logic signed [12:0]           p_d, q_d;
	logic signed [25:0]           p_sq_d, q_sq_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= ssp_pkg::SCREEN_WIDTH_RST;
			screen_height_q <= ssp_pkg::SCREEN_HEIGHT_RST;
		end else if (wr_en) begin
			if (wr_index == ssp_pkg::REG_SCREEN_WIDTH) begin
				screen_width_q <= wr_data;
			end else if (wr_index == ssp_pkg::REG_SCREEN_HEIGHT) begin
				screen_height_q <= wr_data;
			end
		end
	end

	// reference length squared, recomputed every cycle from the registers
	assign p_d = signed'({2'b00, screen_width_q[11:1]}) - signed'({1'b0, screen_height_q});
	assign q_d = signed'({2'b00, screen_height_q[11:1]}) - signed'({1'b0, screen_width_q});
	assign p_sq_d = p_d * p_d;
	assign q_sq_d = q_d * q_d;

	always_ff @(posedge clk) begin
		p2_q <= p_sq_d[RB-2:0];
		q2_q <= q_sq_d[RB-2:0];
		r2_q <= RB'(p2_q) + RB'(q2_q);
	end

	// ---------------- stage 1: differences ----------------
	logic                 vld_s1, vld_s2;
	logic signed [CB:0]   dx_s1, dy_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= (CB+1)'(source_x) - (CB+1)'(listener_x);
		dy_s1 <= (CB+1)'(source_y) - (CB+1)'(listener_y);
	end

	// ---------------- stage 2: legs, flags, squares ----------------
	logic [CB-1:0]       adx_d, ady_d;
	logic [CB-1:0]       a_s2, b_s2;
	logic [2*CB-1:0]     sqx_s2, sqy_s2;
	ssp_pkg::ssp_flags_t fl_s2;

	assign adx_d = dx_s1[CB] ? CB'(-dx_s1) : CB'(dx_s1);
	assign ady_d = dy_s1[CB] ? CB'(-dy_s1) : CB'(dy_s1);

	always_ff @(posedge clk) begin
		if (!dx_s1[CB] && dx_s1 != '0) begin
			a_s2 <= ady_d;
			b_s2 <= adx_d;
			fl_s2.a_zero <= (ady_d == '0);
			fl_s2.a_eq_b <= (ady_d == adx_d);
		end else begin
			a_s2 <= adx_d;
			b_s2 <= ady_d;
			fl_s2.a_zero <= (adx_d == '0);
			fl_s2.a_eq_b <= (adx_d == ady_d);
		end
		fl_s2.dx_pos  <= !dx_s1[CB] && dx_s1 != '0;
		fl_s2.dy_pos  <= !dy_s1[CB] && dy_s1 != '0;
		fl_s2.dy_zero <= (dy_s1 == '0);
		sqx_s2 <= adx_d * adx_d;
		sqy_s2 <= ady_d * ady_d;
	end

	// ---------------- CORDIC and distance chains ----------------
	logic                  vld_s [N+1];
	ssp_pkg::ssp_flags_t   fl_s  [N+1];
	logic signed [CW-1:0]  cx_s  [N+1];
	logic signed [CW-1:0]  cy_s  [N+1];
	logic signed [ZW-1:0]  cz_s  [N+1];
	logic [SW-1:0]         rhs_s [N+1];   // d2 at stage 1, 127^2*d2 after
	logic [SW-1:0]         ss_s  [N+1];   // n^2 * r2
	logic [SW-1:0]         tt_s  [N+1];   // n * r2
	logic [NB-1:0]         n_s   [N+1];

	assign vld_s[0] = vld_s2;
	assign fl_s[0]  = fl_s2;
	assign cx_s[0]  = CW'(b_s2) <<< SH;
	assign cy_s[0]  = CW'(a_s2) <<< SH;
	assign cz_s[0]  = '0;
	assign rhs_s[0] = SW'(sqx_s2);
	assign ss_s[0]  = SW'(sqy_s2);
	assign tt_s[0]  = '0;
	assign n_s[0]   = '0;

	for (genvar j = 1; j <= N; j++) begin : g_stage
		localparam logic signed [ZW-1:0] TAB = ssp_pkg::atan_q16(j - 1);
		localparam int K = ssp_pkg::DIST_STAGES - j;   // search bit at this stage

		logic signed [CW-1:0] xs_d, ys_d;
		assign xs_d = cx_s[j-1] >>> (j - 1);
		assign ys_d = cy_s[j-1] >>> (j - 1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			fl_s[j] <= fl_s[j-1];
			if (cy_s[j-1] > 0) begin
				cx_s[j] <= cx_s[j-1] + ys_d;
				cy_s[j] <= cy_s[j-1] - xs_d;
				cz_s[j] <= cz_s[j-1] + TAB;
			end else begin
				cx_s[j] <= cx_s[j-1] - ys_d;
				cy_s[j] <= cy_s[j-1] + xs_d;
				cz_s[j] <= cz_s[j-1] - TAB;
			end
		end

		if (j == 1) begin : g_d2
			always_ff @(posedge clk) begin
				rhs_s[j] <= rhs_s[j-1] + ss_s[j-1];
				ss_s[j]  <= '0;
				tt_s[j]  <= '0;
				n_s[j]   <= '0;
			end
		end else if (j == 2) begin : g_rhs
			always_ff @(posedge clk) begin
				rhs_s[j] <= SW'(D2W'(rhs_s[j-1]) * ssp_pkg::DIST_SCALE_SQ);
				ss_s[j]  <= '0;
				tt_s[j]  <= '0;
				n_s[j]   <= '0;
			end
		end else if (j <= ssp_pkg::DIST_STAGES) begin : g_search
			// try n + 2^K: (n+2^K)^2 r2 = S + 2^(K+1) T + 2^(2K) r2
			logic [SW-1:0] cand_d;
			assign cand_d = ss_s[j-1] + (tt_s[j-1] << (K + 1)) + (SW'(r2_q) << (2 * K));
			always_ff @(posedge clk) begin
				rhs_s[j] <= rhs_s[j-1];
				if (cand_d <= rhs_s[j-1]) begin
					ss_s[j] <= cand_d;
					tt_s[j] <= tt_s[j-1] + (SW'(r2_q) << K);
					n_s[j]  <= n_s[j-1] | (NB'(1) << K);
				end else begin
					ss_s[j] <= ss_s[j-1];
					tt_s[j] <= tt_s[j-1];
					n_s[j]  <= n_s[j-1];
				end
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				rhs_s[j] <= rhs_s[j-1];
				ss_s[j]  <= ss_s[j-1];
				tt_s[j]  <= tt_s[j-1];
				n_s[j]   <= n_s[j-1];
			end
		end
	end

	// ---------------- output stage ----------------
	logic [6:0]          deg_d;
	logic [8:0]          bearing_d;
	logic [7:0]          dist_d;
	logic signed [ZW-1:0] zq_d;

	assign zq_d = cz_s[N] >>> 16;

	always_comb begin
		priority if (fl_s[N].dy_zero || fl_s[N].a_zero) begin
			deg_d = 7'd0;
		end else if (fl_s[N].a_eq_b) begin
			deg_d = 7'd45;
		end else if (cz_s[N] <= 0) begin
			deg_d = 7'd0;
		end else if (zq_d > 89) begin
			deg_d = 7'd89;
		end else begin
			deg_d = 7'(zq_d);
		end

		unique case ({fl_s[N].dx_pos, fl_s[N].dy_pos})
			2'b11:   bearing_d = 9'd90 + 9'(deg_d);
			2'b10:   bearing_d = 9'd90 - 9'(deg_d);
			2'b01:   bearing_d = 9'd180 + 9'(deg_d);
			default: bearing_d = 9'd360 - 9'(deg_d);
		endcase

		priority if (n_s[N] == '0) begin
			dist_d = 8'd1;
		end else if (n_s[N] > 9'd255) begin
			dist_d = 8'd255;
		end else begin
			dist_d = 8'(n_s[N]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		bearing_deg     <= bearing_d;
		scaled_distance <= dist_d;
	end

	// ---------------- assertions ----------------
	`SSP_ASSERT_ALWAYS(a_dist_nonzero, clk, arst_n, !done || scaled_distance != 8'd0, "zero distance")
	`SSP_ASSERT_ALWAYS(a_bearing_range, clk, arst_n, !done || bearing_deg <= 9'd360, "bad bearing")
	`SSP_ASSERT_NEXT(a_chain_done, clk, arst_n, vld_s[N], done, "pipeline beat lost at output")
	`SSP_ASSERT_NEXT(a_s2_follows, clk, arst_n, vld_s1, vld_s2, "pipeline beat lost at stage 2")

endmodule
